// ===== hw/rtl/postfix_stack_evaluator_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define PSEV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PSEV_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/psev_pkg.sv =====
package psev_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] FUNC_PUSH   = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_SUB    = 3'd2;
  localparam logic [2:0] FUNC_MUL    = 3'd3;
  localparam logic [2:0] FUNC_DIV    = 3'd4;
  localparam logic [2:0] FUNC_FINISH = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDER   = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] operand_value;
  } token_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;
    logic [1:0]         status;
    logic               is_answer;
  } result_t;

endpackage

// ===== hw/rtl/psev_ram.sv =====
module psev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/psev_div.sv =====
module psev_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [psev_pkg::DATA_WIDTH-1:0] lhs,
  input  logic [psev_pkg::DATA_WIDTH-1:0] rhs,
  output logic                           done,
  output logic [psev_pkg::DATA_WIDTH-1:0] quotient
);
  import psev_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] divisor;
  logic                  neg;
  logic [DATA_WIDTH:0]   rem_sh;
  logic                  ge;

  assign rem_sh   = {rem, quo[DATA_WIDTH-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // work on magnitudes, fix the sign at the end
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quo     <= lhs[DATA_WIDTH-1] ? (~lhs + 1'b1) : lhs;
        divisor <= rhs[DATA_WIDTH-1] ? (~rhs + 1'b1) : rhs;
        neg     <= lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
      end else if (busy) begin
        rem <= ge ? DATA_WIDTH'(rem_sh - {1'b0, divisor}) : rem_sh[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/postfix_stack_evaluator_core.sv =====
// Push, finish, error and ignored tokens answer from S_IDLE; add/sub go through S_READ;
// multiply S_READ, S_MUL; divide S_READ, S_DIV (one quotient bit per cycle in the divider).
// Throughput: one token at a time; unless the result is stalled, the next token is taken
// the cycle after a result is registered. An operator that passes its checks waits on
// the stack memory read port in S_READ. Reset (rst, synchronous): stack empty, no result
// pending; memory contents are not cleared, entries are only read after they are written.
module postfix_stack_evaluator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              token_valid,
  output logic              token_stall,
  input  psev_pkg::token_t  token,
  output logic              result_valid,
  input  logic              result_stall,
  output psev_pkg::result_t result
);
  import psev_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MUL, S_DIV} state_t;

  state_t                state;
  logic [2:0]            op;
  logic [SP_W-1:0]       sp;
  logic [DATA_WIDTH-1:0] tos;
  logic [DATA_WIDTH-1:0] prod;

  logic                  accept;
  logic                  sp_empty;
  logic                  sp_full;
  logic                  sp_lt2;
  logic [SP_W-1:0]       sp_m1;
  logic [SP_W-1:0]       sp_m2;
  logic [DATA_WIDTH-1:0] top_now;
  logic [DATA_WIDTH-1:0] push_val;
  logic [DATA_WIDTH-1:0] lhs;
  logic [DATA_WIDTH-1:0] res_val;
  logic                  fin;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  div_start;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_q;

  function automatic logic [31:0] to_out(logic [DATA_WIDTH-1:0] v);
    return 32'($signed(v));
  endfunction

  assign token_stall = (state != S_IDLE) || (result_valid && result_stall);
  assign accept      = token_valid && !token_stall;
  assign sp_empty    = (sp == '0);
  assign sp_full     = (sp >= SP_W'(STACK_DEPTH));
  assign sp_lt2      = (sp < SP_W'(2));
  assign sp_m1       = sp - SP_W'(1);
  assign sp_m2       = sp - SP_W'(2);
  assign top_now     = sp_empty ? '0 : tos;
  assign push_val    = DATA_WIDTH'($signed(token.operand_value));

  always_comb begin
    case (state)
      S_READ:  res_val = (op == FUNC_SUB) ? (lhs - tos) : (lhs + tos);
      S_MUL:   res_val = prod;
      S_DIV:   res_val = div_q;
      default: res_val = '0;
    endcase
  end

  assign fin = (state == S_READ && (op == FUNC_ADD || op == FUNC_SUB))
            || (state == S_MUL)
            || (state == S_DIV && div_done);

  // Push writes the free slot; an operator overwrites its left operand.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sp_m2[ADDR_W-1:0];
    wr_data = res_val;
    if (fin) begin
      wr_en = 1'b1;
    end else if (accept && token.func == FUNC_PUSH && !sp_full) begin
      wr_en   = 1'b1;
      wr_addr = sp[ADDR_W-1:0];
      wr_data = push_val;
    end
  end

  assign div_start = (state == S_READ) && (op == FUNC_DIV);

  psev_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(sp_m2[ADDR_W-1:0]),
    .rd_data(lhs)
  );

  psev_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .lhs     (lhs),
    .rhs     (tos),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sp           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op                 <= token.func;
            result_valid       <= 1'b1;
            result.top_value   <= to_out(top_now);
            result.stack_depth <= 7'(sp);
            result.status      <= ST_OK;
            result.is_answer   <= 1'b0;
            case (token.func)
              FUNC_PUSH: begin
                if (sp_full) begin
                  result.status <= ST_OVER;
                end else begin
                  sp                 <= sp + 1'b1;
                  tos                <= push_val;
                  result.top_value   <= to_out(push_val);
                  result.stack_depth <= 7'(sp + 1'b1);
                end
              end
              FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
                if (sp_lt2) begin
                  result.status <= ST_UNDER;
                end else if (token.func == FUNC_DIV && tos == '0) begin
                  result.status <= ST_DIVZERO;
                end else begin
                  // hold the beat until the left operand is back from memory
                  result_valid <= 1'b0;
                  state        <= S_READ;
                end
              end
              FUNC_FINISH: begin
                if (sp_empty) begin
                  result.status <= ST_UNDER;
                end else begin
                  sp                 <= '0;
                  result.top_value   <= to_out(tos);
                  result.stack_depth <= '0;
                  result.is_answer   <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          if (op == FUNC_MUL) begin
            prod  <= DATA_WIDTH'(lhs * tos);
            state <= S_MUL;
          end else if (op == FUNC_DIV) begin
            state <= S_DIV;
          end
        end
        S_MUL: begin
        end
        S_DIV: begin
        end
        default: state <= S_IDLE;
      endcase
      if (fin) begin
        state              <= S_IDLE;
        sp                 <= sp_m1;
        tos                <= res_val;
        result_valid       <= 1'b1;
        result.top_value   <= to_out(res_val);
        result.stack_depth <= 7'(sp_m1);
        result.status      <= ST_OK;
        result.is_answer   <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/psev_checker.sv =====
`include "postfix_stack_evaluator_core_macros.svh"

module psev_checker (
  input logic              clk,
  input logic              rst,
  input logic              token_valid,
  input logic              token_stall,
  input psev_pkg::token_t  token,
  input logic              result_valid,
  input logic              result_stall,
  input psev_pkg::result_t result
);
  import psev_pkg::*;

  logic token_acc;
  logic quick_tok;

  assign token_acc = token_valid && !token_stall;
  // tokens that never touch the arithmetic path answer in the next cycle
  assign quick_tok = token.func == FUNC_PUSH || token.func == FUNC_FINISH
                  || token.func == 3'd6 || token.func == 3'd7;

  `PSEV_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid, "result beat after reset")
  `PSEV_ASSERT(a_quick_result, clk, rst, token_acc && quick_tok |=> result_valid, "quick token gave no beat")
  `PSEV_ASSERT(a_answer_empties, clk, rst, result_valid && result.is_answer |-> result.status == ST_OK && result.stack_depth == 7'd0, "answer beat with error or nonempty stack")
  `PSEV_ASSERT(a_beat_held, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result beat changed")

endmodule

bind postfix_stack_evaluator_core psev_checker u_psev_checker (.*);

// ===== verif/psev_stack_checker.sv =====
`timescale 1ns / 100ps

module psev_stack_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              token_valid,
  input  logic              token_stall,
  input  psev_pkg::token_t  token,
  input  logic              result_valid,
  input  logic              result_stall,
  input  psev_pkg::result_t result,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                answers,
  output int                faults
);
  import psev_pkg::*;

  logic signed [31:0] operand_mem [STACK_DEPTH];
  int                 held_depth;
  result_t            stack_reports [$];
  result_t            want;
  int                 errs;
  int                 n_checked;
  int                 n_answers;
  int                 n_faults;

  // Apply one token to the shadow stack and return the report it should produce.
  function automatic result_t apply_token(token_t t);
    result_t            r;
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    logic signed [31:0] q;
    longint             wide;
    r.status    = ST_OK;
    r.is_answer = 1'b0;
    r.top_value = '0;
    q           = '0;
    case (t.func)
      FUNC_PUSH: begin
        if (held_depth >= STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          operand_mem[held_depth] = t.operand_value;
          held_depth++;
        end
      end
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
        if (held_depth < 2) begin
          r.status = ST_UNDER;
        end else begin
          rhs = operand_mem[held_depth - 1];
          lhs = operand_mem[held_depth - 2];
          case (t.func)
            FUNC_ADD: q = lhs + rhs;
            FUNC_SUB: q = lhs - rhs;
            FUNC_MUL: q = lhs * rhs;
            default: begin
              if (rhs == 0) begin
                r.status = ST_DIVZERO;
              end else begin
                // widen so that the most negative value over minus one wraps cleanly
                wide = longint'(lhs) / longint'(rhs);
                q    = wide[31:0];
              end
            end
          endcase
          if (r.status == ST_OK) begin
            held_depth--;
            operand_mem[held_depth - 1] = q;
          end
        end
      end
      FUNC_FINISH: begin
        if (held_depth == 0) begin
          r.status = ST_UNDER;
        end else begin
          r.top_value = operand_mem[held_depth - 1];
          r.is_answer = 1'b1;
          held_depth  = 0;
        end
      end
      default: ;
    endcase
    if (!r.is_answer) r.top_value = (held_depth == 0) ? '0 : operand_mem[held_depth - 1];
    r.stack_depth = 7'(held_depth);
    return r;
  endfunction

  task automatic check_field(string name, logic signed [32:0] want_v, logic signed [32:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_depth = 0;
      stack_reports.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (stack_reports.size() == 0) begin
          $error("result beat with no token outstanding: top_value %0d", result.top_value);
          errs++;
        end else begin
          want = stack_reports.pop_front();
          n_checked++;
          if (want.is_answer) n_answers++;
          if (want.status != ST_OK) n_faults++;
          check_field("top_value", 33'($signed(want.top_value)),
                      33'($signed(result.top_value)));
          check_field("stack_depth", 33'(want.stack_depth), 33'(result.stack_depth));
          check_field("status", 33'(want.status), 33'(result.status));
          check_field("is_answer", 33'(want.is_answer), 33'(result.is_answer));
        end
      end
      if (token_valid && !token_stall) stack_reports.push_back(apply_token(token));
    end
    fail_count <= errs;
    pending    <= stack_reports.size();
    checked    <= n_checked;
    answers    <= n_answers;
    faults     <= n_faults;
  end

endmodule

// ===== verif/postfix_stack_evaluator_core_tb.sv =====
`timescale 1ns / 100ps

module postfix_stack_evaluator_core_tb;
  import psev_pkg::*;

  localparam int MAX_CYCLES    = 1_000_000;
  localparam int RANDOM_TOKENS = 1350;
  localparam int DRAIN_CYCLES  = 60;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    token_valid  = 1'b0;
  logic    token_stall;
  token_t  token        = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int fail_count;
  int pending;
  int checked;
  int answers;
  int faults;
  int cycles        = 0;
  int sent          = 0;
  int overflow_runs = 0;
  int stall_left    = 0;
  bit calm          = 1'b0;

  always #6 clk = ~clk;

  postfix_stack_evaluator_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token        (token),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  psev_stack_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token        (token),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .answers      (answers),
    .faults       (faults)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  function automatic token_t make_token(logic [2:0] f, logic signed [31:0] v);
    token_t t;
    t.func          = f;
    t.operand_value = v;
    return t;
  endfunction

  // Hold valid across back-to-back beats; drop it only when a gap comes before a token.
  task automatic send_token(token_t t);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      token_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    token       <= t;
    token_valid <= 1'b1;
    do @(posedge clk); while (token_stall);
    sent++;
  endtask

  task automatic run_expression();
    int     want_push;
    int     pushed;
    int     held;
    token_t t;
    want_push = $urandom_range(1, 12);
    pushed    = 0;
    held      = 0;
    while (pushed < want_push || held > 1) begin
      if (held < 2 || (pushed < want_push && $urandom_range(0, 1) == 1)) begin
        t = make_token(FUNC_PUSH, pick_value());
        pushed++;
        held++;
      end else begin
        t = make_token(3'($urandom_range(FUNC_ADD, FUNC_DIV)), $urandom());
        held--;
      end
      send_token(t);
    end
    send_token(make_token(FUNC_FINISH, $urandom()));
  endtask

  // Push past the top of the stack, then fold a few entries and finish.
  task automatic run_fill();
    int n_push;
    n_push = $urandom_range(STACK_DEPTH + 2, STACK_DEPTH + 8);
    overflow_runs++;
    repeat (n_push) send_token(make_token(FUNC_PUSH, pick_value()));
    repeat ($urandom_range(1, 6))
      send_token(make_token(3'($urandom_range(FUNC_ADD, FUNC_DIV)), $urandom()));
    send_token(make_token(FUNC_FINISH, $urandom()));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 8)) send_token(make_token(3'($urandom_range(0, 7)), $urandom()));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < 35);
      stall_left   <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    token_t opening [$];
    int     pick;
    opening = '{
      make_token(FUNC_FINISH, 32'sd0),          // finish on empty stack
      make_token(FUNC_ADD, 32'sd5),             // operator on empty stack
      make_token(FUNC_PUSH, 32'sh7fffffff),
      make_token(FUNC_SUB, 32'sd0),             // operator with one entry
      make_token(FUNC_PUSH, 32'sd1),
      make_token(FUNC_ADD, 32'sd0),             // wraps to most negative
      make_token(FUNC_PUSH, -32'sd1),
      make_token(FUNC_DIV, 32'sd0),             // most negative over minus one
      make_token(FUNC_PUSH, 32'sd0),
      make_token(FUNC_DIV, 32'sd0),             // divide by zero
      make_token(3'd6, 32'sh5a5a5a5a),
      make_token(3'd7, 32'sha5a5a5a5),
      make_token(FUNC_PUSH, 32'sd3),
      make_token(FUNC_MUL, 32'sd0),
      make_token(FUNC_PUSH, -32'sd7),
      make_token(FUNC_PUSH, 32'sd2),
      make_token(FUNC_DIV, 32'sd0),             // truncates toward zero
      make_token(FUNC_SUB, 32'sd0),
      make_token(FUNC_PUSH, 32'sh80000000),
      make_token(FUNC_MUL, 32'sd0),
      make_token(FUNC_FINISH, 32'sd0),
      make_token(FUNC_PUSH, 32'sd0),
      make_token(FUNC_FINISH, 32'sd0)           // answer of zero
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (opening[i]) send_token(opening[i]);

    while (sent < RANDOM_TOKENS + opening.size()) begin
      calm = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 62) run_expression();
      else if (pick < 70) run_fill();
      else run_noise();
    end
    token_valid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d tokens in %0d cycles, %0d stack-overflow runs", sent, cycles,
             overflow_runs);
    $display("checked %0d reports: %0d answers, %0d error statuses", checked, answers, faults);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
